// ===== hw/rtl/iqrog_pkg.sv =====
// Shared types and constants of the IQR window outlier gate.
package iqrog_pkg;

  localparam int unsigned Channels = 6;
  localparam int unsigned Angles   = 3;
  localparam int unsigned FieldW   = 32;
  localparam int unsigned GainW    = 4;
  localparam int unsigned UnwrapW  = 36;
  localparam int unsigned ModSteps = 10;
  localparam int unsigned StepW    = 4;

  localparam logic [GainW-1:0]          GainReset = 4'd6;
  localparam logic signed [UnwrapW-1:0] HalfTurn  = 36'sd11796480;
  localparam logic signed [UnwrapW-1:0] FullTurn  = 36'sd23592960;
  // 256 full turns: lifts any difference of two 32-bit angles above zero
  localparam logic signed [UnwrapW-1:0] TurnBias  = 36'sd6039797760;
  localparam logic signed [UnwrapW-1:0] Int32Max  = 36'sd2147483647;
  localparam logic signed [UnwrapW-1:0] Int32Min  = -36'sd2147483648;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_SCAN,
    ST_SPAN,
    ST_CHECK,
    ST_STORE,
    ST_OUTPUT
  } state_e;

  typedef struct packed {
    logic load;
    logic unwrap_step;
    logic finish;
    logic scan_clear;
    logic scan_run;
    logic span;
    logic check;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic unwrap_done;
    logic full;
    logic scan_done;
  } sts_t;

endpackage

// ===== hw/rtl/iqrog_ctrl.sv =====
// Sequencer of the IQR window outlier gate.
module iqrog_ctrl
  import iqrog_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UNWRAP;
      end
      ST_UNWRAP: begin
        if (sts_i.unwrap_done) state_d = sts_i.full ? ST_SCAN : ST_STORE;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_SPAN;
      end
      ST_SPAN:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_STORE;
      ST_STORE: state_d = ST_OUTPUT;
      ST_OUTPUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_UNWRAP: begin
        cmd_o.unwrap_step = !sts_i.unwrap_done;
        cmd_o.finish      = sts_i.unwrap_done;
        cmd_o.scan_clear  = sts_i.unwrap_done && sts_i.full;
      end
      ST_SCAN:   cmd_o.scan_run = 1'b1;
      ST_SPAN:   cmd_o.span = 1'b1;
      ST_CHECK:  cmd_o.check = 1'b1;
      ST_STORE:  cmd_o.store = 1'b1;
      ST_OUTPUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_load_unwrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_UNWRAP)
    else $error("load did not start unwrap");
  a_scan_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> sts_i.full)
    else $error("scan on a window that is not full");
  a_store_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |=> out_valid_o)
    else $error("store not followed by output word");
`endif

endmodule

// ===== hw/rtl/iqrog_datapath.sv =====
// Datapath: angle unwrap, history windows, quartile scan and fence test.
module iqrog_datapath
  import iqrog_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic [Channels*FieldW-1:0] in_data_i,
  input  logic                       cfg_we_i,
  input  logic [GainW-1:0]           cfg_wdata_i,
  output logic [Channels*FieldW-1:0] out_data_o,
  output logic                       out_acc_o
);

  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned FW = SAMPLE_BITS + 6;
  localparam logic [CW-1:0] Rank1 = CW'(WINDOW_DEPTH / 4 - 1);
  localparam logic [CW-1:0] Rank3 = CW'((3 * WINDOW_DEPTH) / 4);
  localparam logic [CW-1:0] Depth = CW'(WINDOW_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(WINDOW_DEPTH - 1);
  localparam logic signed [64:0] SatHi = (65'sd1 <<< (S - 1)) - 65'sd1;
  localparam logic signed [64:0] SatLo = -SatHi - 65'sd1;

  logic [GainW-1:0]        gain_q;
  logic [CW-1:0]           fill_q;
  logic [IW-1:0]           slot_q;
  logic signed [FieldW-1:0] prev_q [Angles];
  logic signed [FieldW-1:0] val_q  [Channels];
  logic [UnwrapW-1:0]      rem_q  [Angles];
  logic [StepW-1:0]        step_q;
  logic                    ok_q;
  logic [IW-1:0]           i_q, j_q;
  logic                    iss_q;
  logic                    rv_q, rfirst_q, rlastj_q, rlast_q;
  logic [Channels*FieldW-1:0] out_data_q;
  logic                    out_acc_q;
  logic [Channels-1:0]     bad;

  assign sts_o.unwrap_done = (step_q == StepW'(ModSteps));
  assign sts_o.full        = (fill_q == Depth);
  assign sts_o.scan_done   = rv_q && rlast_q;
  assign out_data_o        = out_data_q;
  assign out_acc_o         = out_acc_q;

  // Hold the fence gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // Unwrap step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.unwrap_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  // Latch positions; reduce angle differences by one shifted turn per cycle
  for (genvar c = 0; c < 3; c++) begin : g_pos
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) val_q[c] <= in_data_i[c*FieldW +: FieldW];
    end
  end

  for (genvar a = 0; a < Angles; a++) begin : g_ang
    logic signed [UnwrapW-1:0] diff;
    logic [UnwrapW-1:0]        sub;
    logic signed [UnwrapW-1:0] res;
    logic signed [FieldW-1:0]  res_sat;

    assign diff = UnwrapW'($signed(in_data_i[(3+a)*FieldW +: FieldW]))
                  - UnwrapW'(prev_q[a]) + HalfTurn + TurnBias;
    assign sub  = FullTurn << (StepW'(ModSteps - 1) - step_q);
    assign res  = UnwrapW'(prev_q[a]) + $signed(rem_q[a]) - HalfTurn;

    always_comb begin
      if (res > Int32Max) begin
        res_sat = Int32Max[FieldW-1:0];
      end else if (res < Int32Min) begin
        res_sat = Int32Min[FieldW-1:0];
      end else begin
        res_sat = res[FieldW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        rem_q[a] <= diff;
      end else if (cmd_i.unwrap_step && rem_q[a] >= sub) begin
        rem_q[a] <= rem_q[a] - sub;
      end
      if (cmd_i.finish) val_q[3+a] <= res_sat;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q[a] <= '0;
      end else if (cmd_i.finish) begin
        prev_q[a] <= res_sat;
      end
    end
  end

  // Scan address counters and read pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q      <= '0;
      j_q      <= '0;
      iss_q    <= 1'b0;
      rv_q     <= 1'b0;
      rfirst_q <= 1'b0;
      rlastj_q <= 1'b0;
      rlast_q  <= 1'b0;
    end else begin
      rv_q     <= cmd_i.scan_run && iss_q;
      rfirst_q <= (j_q == '0);
      rlastj_q <= (j_q == LastIdx);
      rlast_q  <= (j_q == LastIdx) && (i_q == LastIdx);
      if (cmd_i.scan_clear) begin
        i_q   <= '0;
        j_q   <= '0;
        iss_q <= 1'b1;
      end else if (cmd_i.scan_run && iss_q) begin
        if (j_q == LastIdx) begin
          j_q <= '0;
          i_q <= i_q + IW'(1);
          if (i_q == LastIdx) iss_q <= 1'b0;
        end else begin
          j_q <= j_q + IW'(1);
        end
      end
    end
  end

  // Per-channel window, rank counting and fence test
  for (genvar c = 0; c < Channels; c++) begin : g_ch
    logic signed [S-1:0]  mem [WINDOW_DEPTH];
    logic signed [S-1:0]  rd_a_q, rd_b_q;
    logic signed [S-1:0]  samp;
    logic signed [64:0]   wide;
    logic [CW-1:0]        lt_q, le_q, lt_n, le_n;
    logic signed [S-1:0]  q1_q, q3_q;
    logic signed [FW-1:0] span_q, up, dn;

    // Saturate the sample to the stored width
    assign wide = 65'(val_q[c]);
    always_comb begin
      if (wide > SatHi) begin
        samp = SatHi[S-1:0];
      end else if (wide < SatLo) begin
        samp = SatLo[S-1:0];
      end else begin
        samp = wide[S-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.store) mem[slot_q] <= samp;
    end

    always_ff @(posedge clk_i) begin
      rd_a_q <= mem[i_q];
      rd_b_q <= mem[j_q];
    end

    assign lt_n = (rfirst_q ? '0 : lt_q) + CW'(rd_b_q < rd_a_q);
    assign le_n = (rfirst_q ? '0 : le_q) + CW'(rd_b_q <= rd_a_q);

    // Pick the candidate whose rank range covers each quartile
    always_ff @(posedge clk_i) begin
      if (rv_q) begin
        lt_q <= lt_n;
        le_q <= le_n;
        if (rlastj_q) begin
          if (lt_n <= Rank1 && Rank1 < le_n) q1_q <= rd_a_q;
          if (lt_n <= Rank3 && Rank3 < le_n) q3_q <= rd_a_q;
        end
      end
      if (cmd_i.span) begin
        span_q <= $signed({1'b0, gain_q}) * (FW'(q3_q) - FW'(q1_q));
      end
    end

    assign up     = (FW'(samp) - FW'(q3_q)) <<< 2;
    assign dn     = (FW'(q1_q) - FW'(samp)) <<< 2;
    assign bad[c] = (up > span_q) || (dn > span_q);
  end

  // Fill count, write slot, verdict and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      slot_q <= '0;
      ok_q   <= 1'b1;
    end else begin
      if (cmd_i.load) ok_q <= 1'b1;
      if (cmd_i.check && (|bad)) ok_q <= 1'b0;
      if (cmd_i.store) begin
        slot_q <= (slot_q == LastIdx) ? '0 : slot_q + IW'(1);
        if (fill_q != Depth) fill_q <= fill_q + CW'(1);
      end
    end
  end

  for (genvar c = 0; c < Channels; c++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (cmd_i.store) out_data_q[c*FieldW +: FieldW] <= val_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) out_acc_q <= ok_q;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Depth)
    else $error("fill count beyond window depth");
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastIdx)
    else $error("write slot beyond window");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepW'(ModSteps))
    else $error("unwrap step count beyond last step");
`endif

endmodule

// ===== hw/rtl/iqr_window_outlier_gate.sv =====
// Top level of the IQR window outlier gate.
// Takes one six-axis pose word, unwraps roll, pitch and yaw to within a half
// turn of the previous angle, and, once the window is full, flags the word as
// rejected when any channel lies strictly outside Q1 - g*IQR .. Q3 + g*IQR of
// its last WINDOW_DEPTH samples (g = gain/4). One word is in flight at a time.
// While the window fills, the word skips the scan and is accepted; once it is
// full, a rank scan reads each window through two memory ports, one
// candidate-comparand pair per cycle, and the result is held until the master
// side takes it. The gain register is written by cfg_we_i.
module iqr_window_outlier_gate
  import iqrog_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // meas_x, meas_y, meas_z, roll_in, pitch_in, yaw_in (32 bits each)
  input  logic [191:0]     s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_x, out_y, out_z, roll_unwrapped, pitch_unwrapped, yaw_unwrapped
  output logic [191:0]     m_axis_tdata,
  // accepted
  output logic [0:0]       m_axis_tuser,
  input  logic             cfg_we_i,
  input  logic [GainW-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  iqrog_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iqrog_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (m_axis_tdata),
    .out_acc_o   (m_axis_tuser[0])
  );

endmodule
